@@ hw/rtl/filtered_nested_loop_join_bitmap_core_defines.svh @@
// Assertion macros for the join core checker
`ifndef FILTERED_NESTED_LOOP_JOIN_BITMAP_CORE_DEFINES_SVH
`define FILTERED_NESTED_LOOP_JOIN_BITMAP_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FNLJB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define FNLJB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/fnljb_pkg.sv @@
// Package: types and constants of the filtered nested-loop join core
`timescale 1ns / 1ps
`default_nettype none
package fnljb_pkg;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned ROW_W      = 8;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned MASK_W     = 64;
  localparam int unsigned MASK_IDX_W = 6;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned TOTAL_W    = 24;
  localparam int unsigned KEY_SX_W   = 64;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PROBE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic REG_BUILD_THR = 1'b0;
  localparam logic REG_PROBE_THR = 1'b1;
  localparam int unsigned REG_SEL_BIT = 2;

  localparam logic signed [VAL_W-1:0] BUILD_THR_RST = 32'sd48;
  localparam logic signed [VAL_W-1:0] PROBE_THR_RST = 32'sd64;
  localparam logic [TOTAL_W-1:0]      TOTAL_MAX     = 24'hFF_FFFF;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [ROW_W-1:0]        row_index;
    logic signed [VAL_W-1:0] key_value;
    logic signed [VAL_W-1:0] filter_value;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0]   probe_index;
    logic [MASK_W-1:0]  match_mask;
    logic [COUNT_W-1:0] match_count;
    logic [TOTAL_W-1:0] total_matches;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic build_pass;
    logic probe;
    logic probe_pass;
    logic clear;
  } fnljb_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_LAST = 4'b0100,
    ST_DONE = 4'b1000
  } fnljb_state_t;

endpackage
`default_nettype wire

@@ hw/rtl/filtered_nested_loop_join_bitmap_core.sv @@
// Top level of the filtered nested-loop equi-join core with match bitmap
//
// Input words are accepted at a rising edge with start high and busy low.
// kind LOAD writes the key of one build slot and sets its valid bit when the
// filter value is below build_threshold, else clears it; slots at or beyond BUILD_ROWS drop.
// kind CLEAR zeroes all valid bits and the running total; keys are kept.
// Both give no result; busy stays low.
// kind PROBE reads the key memory one slot per cycle and compares every valid
// key with the probe key (when the probe passes probe_threshold), building
// the match mask, its count and the saturating running total.
// A probe keeps busy high through the scan of all BUILD_ROWS slots and the
// LAST and DONE states, the scan being set by the single read port of the key
// memory; out_strobe rises at the edge where busy falls and holds for one
// cycle, and the next probe can be accepted from the strobe cycle on.
// The result must be taken in its strobe cycle; the receiver cannot stall.
// Thresholds sit at byte addresses 0 and 4 of the APB port; the user writes
// them only while the core is idle, which the core does not enforce.
// Synchronous reset clears valid bits and the total, sets thresholds to 48 and 64; key memory contents are not reset.
`timescale 1ns / 1ps
`default_nettype none
module filtered_nested_loop_join_bitmap_core
  import fnljb_pkg::*;
#(
  parameter int unsigned BUILD_ROWS = 64,
  parameter int unsigned KEY_WIDTH  = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_word_t              in_word,
  output logic                       out_strobe,
  output out_word_t                  out_word,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned IDX_W = (BUILD_ROWS > 1) ? $clog2(BUILD_ROWS) : 1;

  logic signed [VAL_W-1:0]    build_thr_r;
  logic signed [VAL_W-1:0]    probe_thr_r;
  logic                       cfg_wr;
  logic                       accept;
  logic                       in_range;
  logic signed [KEY_SX_W-1:0] key_sx;
  logic [KEY_WIDTH-1:0]       key_bits;
  logic [IDX_W-1:0]           slot;
  fnljb_cmd_t                 cmd;
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic [KEY_WIDTH-1:0]       rd_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      build_thr_r <= BUILD_THR_RST;
      probe_thr_r <= PROBE_THR_RST;
    end else if (cfg_wr) begin
      if (paddr[REG_SEL_BIT] == REG_PROBE_THR) begin
        probe_thr_r <= pwdata;
      end else begin
        build_thr_r <= pwdata;
      end
    end
  end

  assign prdata = (paddr[REG_SEL_BIT] == REG_BUILD_THR) ? build_thr_r : probe_thr_r;

  assign accept   = start && !busy;
  assign in_range = ({1'b0, in_word.row_index} < (ROW_W + 1)'(BUILD_ROWS));
  assign key_sx   = KEY_SX_W'(in_word.key_value);
  assign key_bits = key_sx[KEY_WIDTH-1:0];
  assign slot     = in_word.row_index[IDX_W-1:0];

  assign cmd.load       = accept && (in_word.kind == KIND_LOAD) && in_range;
  assign cmd.build_pass = (in_word.filter_value < build_thr_r);
  assign cmd.probe      = accept && (in_word.kind == KIND_PROBE);
  assign cmd.probe_pass = (in_word.filter_value < probe_thr_r);
  assign cmd.clear      = accept && (in_word.kind == KIND_CLEAR);

  fnljb_key_mem #(
    .DEPTH  (BUILD_ROWS),
    .WIDTH  (KEY_WIDTH),
    .ADDR_W (IDX_W)
  ) u_key_mem (
    .clk     (clk),
    .wr_en   (cmd.load),
    .wr_addr (slot),
    .wr_data (key_bits),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fnljb_scan #(
    .BUILD_ROWS (BUILD_ROWS),
    .KEY_WIDTH  (KEY_WIDTH),
    .IDX_W      (IDX_W)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .slot        (slot),
    .probe_key   (key_bits),
    .probe_index (in_word.row_index),
    .busy        (busy),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .out_strobe  (out_strobe),
    .out_word    (out_word)
  );

endmodule
`default_nettype wire

@@ hw/rtl/fnljb_key_mem.sv @@
// Build key memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module fnljb_key_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/fnljb_scan.sv @@
// Probe sequencer: valid bits, key scan, match bitmap, running total
`timescale 1ns / 1ps
`default_nettype none
module fnljb_scan
  import fnljb_pkg::*;
#(
  parameter int unsigned BUILD_ROWS = 64,
  parameter int unsigned KEY_WIDTH  = 32,
  parameter int unsigned IDX_W      = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fnljb_cmd_t           cmd,
  input  wire logic [IDX_W-1:0]     slot,
  input  wire logic [KEY_WIDTH-1:0] probe_key,
  input  wire logic [ROW_W-1:0]     probe_index,
  output logic                      busy,
  output logic                      rd_en,
  output logic [IDX_W-1:0]          rd_addr,
  input  wire logic [KEY_WIDTH-1:0] rd_data,
  output logic                      out_strobe,
  output out_word_t                 out_word
);

  fnljb_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]      addr_r, addr_nxt;
  logic                  rd_vld_r;
  logic [IDX_W-1:0]      rd_idx_r;
  logic [KEY_WIDTH-1:0]  key_r;
  logic                  pass_r;
  logic [ROW_W-1:0]      pidx_r;
  logic [MASK_W-1:0]     mask_r, mask_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [TOTAL_W-1:0]    total_r;
  logic [TOTAL_W:0]      total_sum;
  logic [TOTAL_W-1:0]    total_sat;
  logic [BUILD_ROWS-1:0] valid_r;
  logic                  out_valid_r;
  out_word_t             out_word_r;
  logic                  last_addr;
  logic                  hit;

  assign last_addr = (addr_r == IDX_W'(BUILD_ROWS - 1));
  assign hit       = rd_vld_r && pass_r && valid_r[rd_idx_r] && (rd_data == key_r);
  assign total_sum = {1'b0, total_r} + (TOTAL_W + 1)'(count_r);
  assign total_sat = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    mask_nxt  = mask_r;
    count_nxt = count_r;
    if (hit) begin
      mask_nxt[MASK_IDX_W'(rd_idx_r)] = 1'b1;
      count_nxt = count_r + COUNT_W'(1);
    end
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.probe) begin
          state_nxt = ST_SCAN;
          addr_nxt  = '0;
          mask_nxt  = '0;
          count_nxt = '0;
        end
      end
      ST_SCAN: begin
        addr_nxt = addr_r + IDX_W'(1);
        if (last_addr) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      valid_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= (state_r == ST_SCAN);
      out_valid_r <= (state_r == ST_DONE);
      if (cmd.clear) begin
        valid_r <= '0;
        total_r <= '0;
      end else begin
        if (cmd.load) begin
          valid_r[slot] <= cmd.build_pass;
        end
        if (state_r == ST_DONE) begin
          total_r <= total_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    rd_idx_r <= addr_r;
    mask_r   <= mask_nxt;
    count_r  <= count_nxt;
    if (cmd.probe) begin
      key_r  <= probe_key;
      pass_r <= cmd.probe_pass;
      pidx_r <= probe_index;
    end
    if (state_r == ST_DONE) begin
      out_word_r.probe_index   <= pidx_r;
      out_word_r.match_mask    <= mask_r;
      out_word_r.match_count   <= count_r;
      out_word_r.total_matches <= total_sat;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign rd_en      = (state_r == ST_SCAN);
  assign rd_addr    = addr_r;
  assign out_strobe = out_valid_r;
  assign out_word   = out_word_r;

endmodule
`default_nettype wire

@@ hw/rtl/fnljb_checker.sv @@
// Port-level checker for the join core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "filtered_nested_loop_join_bitmap_core_defines.svh"
module fnljb_checker
  import fnljb_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_word_t  in_word,
  input wire logic      out_strobe,
  input wire out_word_t out_word
);

  `FNLJB_ASSERT_NXT(a_probe_busy, start && !busy && (in_word.kind == KIND_PROBE), busy, "probe accepted without going busy")
  `FNLJB_ASSERT_IMP(a_strobe_idle, out_strobe, !busy, "result word while busy")
  `FNLJB_ASSERT_NXT(a_strobe_single, out_strobe, !out_strobe, "result word repeated")
  `FNLJB_ASSERT_IMP(a_count_mask, out_strobe, ($countones(out_word.match_mask) == out_word.match_count) && (out_word.total_matches >= TOTAL_W'(out_word.match_count)), "count disagrees with mask or total")

endmodule

bind filtered_nested_loop_join_bitmap_core fnljb_checker u_fnljb_checker (.*);
`default_nettype wire
